// File: rtl/xml_text_escaper_utf16_top_defines.svh
// Assertion helpers shared by the escaper modules.
// Each expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef XML_TEXT_ESCAPER_UTF16_TOP_DEFINES_SVH
`define XML_TEXT_ESCAPER_UTF16_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XTE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xte assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define XTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xte assertion failed");

`endif

// File: rtl/xte_pkg.sv
package xte_pkg;

  // One escaped code unit expands to at most six bytes.
  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CntW     = 3;

  typedef logic [MaxBytes-1:0][7:0] byte_vec_t;

  // A group of bytes produced by one input transaction.
  typedef struct packed {
    byte_vec_t       bytes;
    logic [CntW-1:0] cnt;
    logic            str_end;
  } group_t;

  // Entity texts, first character in the top byte, padded with zeros.
  localparam logic [47:0] EntSpace = {"&#32;", 8'h00};
  localparam logic [47:0] EntQuot  = "&quot;";
  localparam logic [47:0] EntAmp   = {"&amp;", 8'h00};
  localparam logic [47:0] EntApos  = "&apos;";
  localparam logic [47:0] EntLt    = {"&lt;", 16'h0000};
  localparam logic [47:0] EntGt    = {"&gt;", 16'h0000};
  localparam logic [47:0] EntDel   = "&#127;";

  // Lay out an entity text so that byte 0 is sent first.
  function automatic byte_vec_t to_bytes(input logic [47:0] s);
    byte_vec_t b;
    for (int k = 0; k < MaxBytes; k++) begin
      b[k] = s[47-8*k -: 8];
    end
    return b;
  endfunction

endpackage

// File: rtl/xte_in_if.sv
interface xte_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

// File: rtl/xte_out_if.sv
interface xte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_end, input string_end,
                output ready);
endinterface

// File: rtl/xte_encode.sv
`include "xml_text_escaper_utf16_top_defines.svh"

module xte_encode (
  input  logic            clk_i,
  input  logic            rst_ni,
  xte_in_if.sink          in_i,
  input  logic            ser_free_i,
  output logic            grp_load_o,
  output xte_pkg::group_t grp_o
);

  // Input register.
  logic        vld_q;
  logic [15:0] unit_q;
  logic        last_q;

  // String state.
  logic        pws_q, pws_d;
  logic        start_q, start_d;
  logic [15:0] held_q, held_d;
  logic        hv_q, hv_d;

  xte_pkg::byte_vec_t       bytes;
  logic [xte_pkg::CntW-1:0] n;
  logic                     advance;
  logic                     is_sur;
  logic                     pair_ok;
  logic [20:0]              cp;
  logic [1:0]               tens;
  logic [4:0]               ones;

  // Pair and control-digit helpers.
  assign is_sur  = (unit_q[15:11] == 5'b11011);
  assign pair_ok = (held_q[15:10] == 6'b110110) && (unit_q[15:10] == 6'b110111);
  assign cp      = {1'b0, held_q[9:0], unit_q[9:0]} + 21'h10000;

  always_comb begin
    if (unit_q[4:0] >= 5'd30) begin
      tens = 2'd3;
      ones = unit_q[4:0] - 5'd30;
    end else if (unit_q[4:0] >= 5'd20) begin
      tens = 2'd2;
      ones = unit_q[4:0] - 5'd20;
    end else if (unit_q[4:0] >= 5'd10) begin
      tens = 2'd1;
      ones = unit_q[4:0] - 5'd10;
    end else begin
      tens = 2'd0;
      ones = unit_q[4:0];
    end
  end

  // Escape and encode the registered code unit.
  always_comb begin
    bytes   = '0;
    n       = '0;
    pws_d   = 1'b0;
    start_d = 1'b0;
    held_d  = held_q;
    hv_d    = 1'b0;
    if (hv_q) begin
      if (pair_ok) begin
        bytes[0] = {5'b11110, cp[20:18]};
        bytes[1] = {2'b10, cp[17:12]};
        bytes[2] = {2'b10, cp[11:6]};
        bytes[3] = {2'b10, cp[5:0]};
        n        = 3'd4;
      end else begin
        bytes[0] = 8'hEF;
        bytes[1] = 8'hBF;
        bytes[2] = 8'hBD;
        n        = 3'd3;
      end
    end else if (is_sur) begin
      if (!last_q) begin
        held_d = unit_q;
        hv_d   = 1'b1;
      end else begin
        bytes[0] = 8'hEF;
        bytes[1] = 8'hBF;
        bytes[2] = 8'hBD;
        n        = 3'd3;
      end
    end else if (unit_q[15:7] != '0) begin
      if (unit_q[15:11] == '0) begin
        bytes[0] = {3'b110, unit_q[10:6]};
        bytes[1] = {2'b10, unit_q[5:0]};
        n        = 3'd2;
      end else begin
        bytes[0] = {4'b1110, unit_q[15:12]};
        bytes[1] = {2'b10, unit_q[11:6]};
        bytes[2] = {2'b10, unit_q[5:0]};
        n        = 3'd3;
      end
    end else if (unit_q[6:5] == 2'b00) begin
      // Control character as a decimal reference.
      bytes[0] = "&";
      bytes[1] = "#";
      if (tens != 2'd0) begin
        bytes[2] = 8'h30 + {6'd0, tens};
        bytes[3] = 8'h30 + {3'd0, ones};
        bytes[4] = ";";
        n        = 3'd5;
      end else begin
        bytes[2] = 8'h30 + {3'd0, ones};
        bytes[3] = ";";
        n        = 3'd4;
      end
    end else begin
      case (unit_q[6:0])
        7'h20: begin
          if (start_q || last_q || pws_q) begin
            bytes = xte_pkg::to_bytes(xte_pkg::EntSpace);
            n     = 3'd5;
          end else begin
            bytes[0] = " ";
            n        = 3'd1;
            pws_d    = 1'b1;
          end
        end
        7'h22: begin
          bytes = xte_pkg::to_bytes(xte_pkg::EntQuot);
          n     = 3'd6;
        end
        7'h26: begin
          bytes = xte_pkg::to_bytes(xte_pkg::EntAmp);
          n     = 3'd5;
        end
        7'h27: begin
          bytes = xte_pkg::to_bytes(xte_pkg::EntApos);
          n     = 3'd6;
        end
        7'h3C: begin
          bytes = xte_pkg::to_bytes(xte_pkg::EntLt);
          n     = 3'd4;
        end
        7'h3E: begin
          bytes = xte_pkg::to_bytes(xte_pkg::EntGt);
          n     = 3'd4;
        end
        7'h7F: begin
          bytes = xte_pkg::to_bytes(xte_pkg::EntDel);
          n     = 3'd6;
        end
        default: begin
          bytes[0] = {1'b0, unit_q[6:0]};
          n        = 3'd1;
        end
      endcase
    end
    // The end of a string returns the state to its reset values.
    if (last_q) begin
      start_d = 1'b1;
      pws_d   = 1'b0;
      hv_d    = 1'b0;
    end
  end

  // Handshake: a held surrogate leaves without a byte group.
  assign advance    = vld_q && ((n == '0) || ser_free_i);
  assign grp_load_o = vld_q && (n != '0) && ser_free_i;
  assign in_i.ready = !vld_q || advance;

  assign grp_o.bytes   = bytes;
  assign grp_o.cnt     = n;
  assign grp_o.str_end = last_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      vld_q <= 1'b1;
    end else if (advance) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      unit_q <= in_i.code_unit;
      last_q <= in_i.last_unit;
    end
  end

  // String state advances with each transaction that leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pws_q   <= 1'b0;
      start_q <= 1'b1;
      hv_q    <= 1'b0;
    end else if (advance) begin
      pws_q   <= pws_d;
      start_q <= start_d;
      hv_q    <= hv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      held_q <= held_d;
    end
  end

  `XTE_ASSERT_SAME(a_held_not_at_start, hv_q, !start_q)
  `XTE_ASSERT_SAME(a_space_not_at_start, start_q, !pws_q)

endmodule

// File: rtl/xte_serialize.sv
`include "xml_text_escaper_utf16_top_defines.svh"

module xte_serialize (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            grp_load_i,
  input  xte_pkg::group_t grp_i,
  output logic            ser_free_o,
  xte_out_if.source       out_o
);

  xte_pkg::group_t          grp_q;
  logic [xte_pkg::CntW-1:0] idx_q;
  logic                     busy_q;
  logic                     pop;
  logic                     run_end;

  // Byte output from the group register.
  assign run_end         = (idx_q == grp_q.cnt - 3'd1);
  assign pop             = busy_q && out_o.ready;
  assign ser_free_o      = !busy_q || (pop && run_end);
  assign out_o.valid     = busy_q;
  assign out_o.out_byte  = grp_q.bytes[idx_q];
  assign out_o.run_end   = run_end;
  assign out_o.string_end = run_end && grp_q.str_end;

  // Group register and byte index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (grp_load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (pop) begin
      if (run_end) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_load_i) begin
      grp_q <= grp_i;
    end
  end

  `XTE_ASSERT_SAME(a_idx_in_group, busy_q, (grp_q.cnt != '0) && (idx_q < grp_q.cnt))
  `XTE_ASSERT_NEXT(a_stall_holds_idx, busy_q && !out_o.ready, busy_q && $stable(idx_q))
  `XTE_ASSERT_SAME(a_load_only_free, grp_load_i, ser_free_o)

endmodule

// File: rtl/xml_text_escaper_utf16_top.sv
// The first byte of a code unit passes the input register and then the group register of
// the byte serializer, which must be free to load it, before it is offered on the output.
// Throughput: one code unit per cycle while each unit yields a single byte and
// the output is ready; a unit of k bytes (up to 6) holds the serializer till all are sent.
// A surrogate that waits for its partner yields no byte and needs no free serializer.
// Reset (rst_ni, asynchronous, active low) empties both registers and starts a new string.
module xml_text_escaper_utf16_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  xte_in_if.sink    in_i,
  xte_out_if.source out_o
);

  logic            ser_free;
  logic            grp_load;
  xte_pkg::group_t grp;

  xte_encode u_encode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .ser_free_i (ser_free),
    .grp_load_o (grp_load),
    .grp_o      (grp)
  );

  xte_serialize u_serialize (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grp_load_i (grp_load),
    .grp_i      (grp),
    .ser_free_o (ser_free),
    .out_o      (out_o)
  );

endmodule
